@@ rtl/mspc_pkg.sv @@
// mspc_pkg: shared types and constants for the motor speed pi controller
// no dependencies
`default_nettype none
package mspc_pkg;
	localparam logic [31:0] EDGE_GAP_MS = 32'd60;
	localparam logic [16:0] INTERVAL_LOW = 17'd1500;
	localparam logic [16:0] INTERVAL_HIGH = 17'd60000;
	localparam logic [26:0] SPEED_NUM = 27'd120000000;
	localparam logic [31:0] RECOVERY_MS = 32'd3000;
	localparam logic [15:0] SETPOINT_RST = 16'd8000;
	localparam int HIST_DEPTH = 5;

	typedef enum logic [2:0] {
		REG_PROP = 3'd0, REG_INTEG = 3'd1, REG_DERIV = 3'd2, REG_RAMP = 3'd3,
		REG_PWM = 3'd4, REG_KICK = 3'd5, REG_TMO = 3'd6, REG_STALL = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_EDGE, ST_SDIV, ST_AVG, ST_ADIV, ST_TICK, ST_CDIV,
		ST_PID0, ST_PID1, ST_PID2, ST_PID3, ST_DUTY, ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic edge_step;
		logic sdiv_start;
		logic hist_write;
		logic adiv_start;
		logic tick_step;
		logic cdiv_start;
		logic [1:0] mac_sel;
		logic mac_en;
		logic duty_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic div_done;
		logic sample_ok;
		logic hold;
	} sts_t;
endpackage
`default_nettype wire

@@ rtl/mspc_div.sv @@
// mspc_div: shared restoring divider, one quotient bit per cycle
// depends on mspc_pkg
`default_nettype none
module mspc_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [35:0] dividend,
	input  wire logic [19:0] divisor,
	output logic             done,
	output logic [35:0]      quotient
);
	logic [35:0] q_q;
	logic [20:0] r_q;
	logic [19:0] d_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [20:0] sh;
	logic [21:0] diff;

	assign sh = {r_q[19:0], q_q[35]};
	assign diff = {1'b0, sh} - {2'b0, d_q};
	assign quotient = q_q;
	assign done = busy_q && (cnt_q == 6'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'd36;
		end else if (busy_q && cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q && cnt_q != 6'd0) begin
			if (!diff[21]) begin
				r_q <= diff[20:0];
				q_q <= {q_q[34:0], 1'b1};
			end else begin
				r_q <= sh;
				q_q <= {q_q[34:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/mspc_ctrl.sv @@
// mspc_ctrl: sequencer for edge and tick processing
// depends on mspc_pkg
`default_nettype none
module mspc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire mspc_pkg::sts_t sts,
	output mspc_pkg::cmd_t     cmd
);
	import mspc_pkg::*;
	state_t state_q, state_d;
	logic   ov_q, ov_d;

	assign out_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		ov_d = ov_q && out_stall;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_EDGE;
				end
			end
			ST_EDGE: begin
				if (sts.is_tick) begin
					state_d = ST_TICK;
				end else begin
					cmd.edge_step = 1'b1;
					if (sts.sample_ok) begin
						cmd.sdiv_start = 1'b1;
						state_d = ST_SDIV;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_SDIV: begin
				if (sts.div_done) begin
					cmd.hist_write = 1'b1;
					state_d = ST_AVG;
				end
			end
			ST_AVG: begin
				cmd.adiv_start = 1'b1;
				state_d = ST_ADIV;
			end
			ST_ADIV: if (sts.div_done) state_d = ST_OUT;
			ST_TICK: begin
				cmd.tick_step = 1'b1;
				if (sts.hold) begin
					state_d = ST_OUT;
				end else begin
					cmd.cdiv_start = 1'b1;
					state_d = ST_CDIV;
				end
			end
			ST_CDIV: if (sts.div_done) state_d = ST_PID0;
			ST_PID0: begin
				cmd.mac_en = 1'b1;
				cmd.mac_sel = 2'd0;
				state_d = ST_PID1;
			end
			ST_PID1: begin
				cmd.mac_en = 1'b1;
				cmd.mac_sel = 2'd1;
				state_d = ST_PID2;
			end
			ST_PID2: begin
				cmd.mac_en = 1'b1;
				cmd.mac_sel = 2'd2;
				state_d = ST_PID3;
			end
			ST_PID3: begin
				cmd.mac_en = 1'b1;
				cmd.mac_sel = 2'd3;
				state_d = ST_DUTY;
			end
			ST_DUTY: begin
				cmd.duty_step = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!ov_q || !out_stall) begin
					cmd.out_load = 1'b1;
					ov_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/mspc_dp.sv @@
// mspc_dp: datapath with measurement, filter, stall logic and pid
// depends on mspc_pkg and mspc_div
`default_nettype none
module mspc_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [19:0]   cfg_data,
	input  wire logic          command,
	input  wire logic [31:0]   now_ms,
	input  wire logic [15:0]   capture_count,
	input  wire logic [11:0]   target_speed,
	input  wire mspc_pkg::cmd_t cmd,
	output mspc_pkg::sts_t     sts,
	output logic [11:0]        duty,
	output logic [12:0]        speed_rpm,
	output logic               edge_valid,
	output logic               stall_active
);
	import mspc_pkg::*;

	logic [19:0] kp_q, ki_q, kd_q;
	logic [7:0]  ramp_q;
	logic [11:0] pwm_q, kick_q;
	logic [15:0] tmo_q, stl_q;

	logic        cmd_q;
	logic [31:0] now_q;
	logic [15:0] cap_q;
	logic [11:0] tgt_q;

	logic [15:0] prev_cap_q;
	logic        first_q;
	logic [31:0] last_edge_q, last_valid_q, stall_t0_q;
	logic [16:0] hist_q [HIST_DEPTH];
	logic [2:0]  widx_q, fill_q;
	logic [16:0] filt_q;
	logic [15:0] setp_q;
	logic signed [23:0] integ_q;
	logic signed [17:0] perr_q;
	logic        armed_q, recov_q;
	logic [11:0] duty_q;
	logic        valid_q;
	logic signed [17:0] err_q;
	logic signed [23:0] integ_new_q;
	logic [23:0] imax_q;
	logic signed [47:0] acc_q;

	logic        div_start, div_done;
	logic [35:0] div_dvd, div_q;
	logic [19:0] div_dvs;

	mspc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(div_dvs), .done(div_done), .quotient(div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= 20'd161409; ki_q <= 20'd5160; kd_q <= '0; ramp_q <= 8'd15;
			pwm_q <= 12'd3360; kick_q <= 12'd300; tmo_q <= 16'd150; stl_q <= 16'd2000;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PROP:  kp_q <= cfg_data;
				REG_INTEG: ki_q <= cfg_data;
				REG_DERIV: kd_q <= cfg_data;
				REG_RAMP:  ramp_q <= cfg_data[7:0];
				REG_PWM:   pwm_q <= cfg_data[11:0];
				REG_KICK:  kick_q <= cfg_data[11:0];
				REG_TMO:   tmo_q <= cfg_data[15:0];
				REG_STALL: stl_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// edge interval
	logic        gap;
	logic [16:0] iv;
	assign gap = (now_q - last_edge_q) > EDGE_GAP_MS;
	assign iv = (cap_q > prev_cap_q) ? {1'b0, cap_q - prev_cap_q}
		: ({1'b0, cap_q} + 17'h10000 - {1'b0, prev_cap_q});
	assign sts.sample_ok = !gap && !first_q && iv > INTERVAL_LOW && iv < INTERVAL_HIGH;
	assign sts.is_tick = cmd_q;
	assign sts.div_done = div_done;

	// tick front end
	logic        tmo_hit;
	logic [16:0] filt_t;
	logic        armed_t, recov_t, hold_t;
	logic [31:0] t0_t;
	assign tmo_hit = (now_q - last_valid_q) > {16'd0, tmo_q};
	assign filt_t = tmo_hit ? 17'd0 : filt_q;
	always_comb begin
		armed_t = armed_q;
		recov_t = recov_q;
		t0_t = stall_t0_q;
		if (filt_t == 17'd0 && setp_q != 16'd0) begin
			if (!armed_q) begin
				armed_t = 1'b1;
				t0_t = now_q;
			end
			if ((now_q - t0_t) > {16'd0, stl_q}) recov_t = 1'b1;
		end else begin
			armed_t = 1'b0;
			recov_t = 1'b0;
		end
		hold_t = recov_t;
		if (recov_t && (now_q - t0_t) > RECOVERY_MS) begin
			recov_t = 1'b0;
			t0_t = now_q;
		end
	end
	assign sts.hold = hold_t;

	// ramp and error
	logic [15:0] tgt16, step16, setp_n;
	logic [16:0] up;
	assign tgt16 = {tgt_q, 4'd0};
	assign step16 = {4'd0, ramp_q, 4'd0};
	assign up = {1'b0, setp_q} + {1'b0, step16};
	always_comb begin
		setp_n = setp_q;
		if (setp_q < tgt16) setp_n = (up > {1'b0, tgt16}) ? tgt16 : up[15:0];
		else if (setp_q > tgt16) setp_n = ((setp_q - tgt16) > step16) ? setp_q - step16 : tgt16;
	end

	logic [2:0]  fill_n;
	logic [19:0] hsum;
	assign fill_n = (fill_q < 3'(HIST_DEPTH)) ? fill_q + 3'd1 : fill_q;
	always_comb begin
		hsum = '0;
		for (int i = 0; i < HIST_DEPTH; i++)
			if (3'(i) < fill_q) hsum = hsum + {3'd0, hist_q[i]};
	end

	always_comb begin
		div_start = cmd.sdiv_start | cmd.adiv_start | cmd.cdiv_start;
		div_dvd = {9'd0, SPEED_NUM};
		div_dvs = {3'd0, iv};
		if (cmd.adiv_start) begin
			div_dvd = {16'd0, hsum};
			div_dvs = {17'd0, fill_q};
		end else if (cmd.cdiv_start) begin
			div_dvd = {4'd0, pwm_q, 20'd0};
			div_dvs = ki_q;
		end
	end

	// clamp and mac operands
	logic [23:0] imax_c;
	logic signed [25:0] integ_sum;
	logic signed [23:0] integ_cl;
	logic signed [18:0] deriv;
	logic [19:0] mgain;
	logic signed [24:0] mop;
	logic signed [45:0] prod;
	assign imax_c = (ki_q < 20'd7) ? {8'd0, pwm_q, 4'd0}
		: ((div_q > 36'd8388607) ? 24'd8388607 : div_q[23:0]);
	assign integ_sum = 26'(integ_q) + 26'(err_q);
	always_comb begin
		if (integ_sum > 26'sd0 + $signed({2'b0, imax_q})) integ_cl = $signed(imax_q);
		else if (integ_sum < -$signed({2'b0, imax_q})) integ_cl = -$signed(imax_q);
		else integ_cl = integ_sum[23:0];
	end
	assign deriv = 19'(err_q) - 19'(perr_q);
	always_comb begin
		case (cmd.mac_sel)
			2'd1: begin mgain = kp_q; mop = 25'(err_q); end
			2'd2: begin mgain = ki_q; mop = 25'(integ_new_q); end
			2'd3: begin mgain = kd_q; mop = 25'(deriv); end
			default: begin mgain = '0; mop = '0; end
		endcase
	end
	assign prod = $signed({1'b0, mgain}) * mop;

	logic signed [47:0] lim, kick;
	assign lim = $signed({16'd0, pwm_q, 20'd0});
	assign kick = $signed({16'd0, kick_q, 20'd0});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command; now_q <= now_ms; cap_q <= capture_count; tgt_q <= target_speed;
		end
		if (cmd.hist_write) hist_q[widx_q] <= div_q[16:0];
		if (cmd.mac_en) begin
			if (cmd.mac_sel == 2'd0) acc_q <= '0;
			else acc_q <= acc_q + 48'(prod);
		end
		if (cmd.mac_en && cmd.mac_sel == 2'd0) begin
			imax_q <= imax_c;
		end
		if (cmd.mac_en && cmd.mac_sel == 2'd1) integ_new_q <= integ_cl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cap_q <= '0; first_q <= 1'b1; last_edge_q <= '0; last_valid_q <= '0;
			widx_q <= '0; fill_q <= '0; filt_q <= '0; setp_q <= SETPOINT_RST;
			integ_q <= '0; perr_q <= '0; armed_q <= 1'b0; recov_q <= 1'b0;
			stall_t0_q <= '0; duty_q <= '0; valid_q <= 1'b0; err_q <= '0;
			duty <= '0; speed_rpm <= '0; edge_valid <= 1'b0; stall_active <= 1'b0;
		end else begin
			if (cmd.load) valid_q <= 1'b0;
			if (cmd.edge_step) begin
				last_edge_q <= now_q;
				prev_cap_q <= cap_q;
				first_q <= 1'b0;
				if (sts.sample_ok) begin
					last_valid_q <= now_q;
					valid_q <= 1'b1;
				end
			end
			if (cmd.hist_write) begin
				widx_q <= (widx_q == 3'(HIST_DEPTH - 1)) ? 3'd0 : widx_q + 3'd1;
				fill_q <= fill_n;
			end
			if (cmd.adiv_start) fill_q <= fill_q;
			if (sts.div_done && !cmd_q && fill_q != 3'd0 && valid_q && !cmd.hist_write)
				filt_q <= div_q[16:0];
			if (cmd.tick_step) begin
				if (tmo_hit) begin
					filt_q <= '0; first_q <= 1'b1; widx_q <= '0; fill_q <= '0;
				end
				armed_q <= armed_t; recov_q <= recov_t; stall_t0_q <= t0_t;
				if (hold_t) begin
					duty_q <= '0; integ_q <= '0;
				end else begin
					setp_q <= setp_n;
					err_q <= 18'($signed({2'b0, setp_n}) - $signed({2'b0, filt_t}));
				end
			end
			if (cmd.mac_en && cmd.mac_sel == 2'd1) integ_q <= integ_cl;
			if (cmd.duty_step) begin
				perr_q <= err_q;
				if (acc_q > lim) duty_q <= pwm_q;
				else if (acc_q > 48'sd524288 && acc_q < kick) duty_q <= kick_q;
				else if (acc_q <= 48'sd524288) duty_q <= '0;
				else duty_q <= acc_q[31:20];
			end
			if (cmd.out_load) begin
				duty <= duty_q;
				speed_rpm <= filt_q[16:4];
				edge_valid <= valid_q;
				stall_active <= recov_q;
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/motor_speed_pi_controller.sv @@
// motor_speed_pi_controller: top level joining sequencer and datapath
// depends on mspc_pkg, mspc_ctrl, mspc_dp
`default_nettype none
// One item at a time. An edge with a valid interval makes two passes of the
// shared divider (speed, then average); other edges skip the divider. A control
// tick makes one divider pass for the integral clamp plus four
// multiply-accumulate steps, or neither during stall recovery. The result sits
// in an output register, so the next item may be accepted while it waits.
module motor_speed_pi_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [19:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        command,
	input  wire logic [31:0] now_ms,
	input  wire logic [15:0] capture_count,
	input  wire logic [11:0] target_speed,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [11:0]      duty,
	output logic [12:0]      speed_rpm,
	output logic             edge_valid,
	output logic             stall_active
);
	import mspc_pkg::*;
	cmd_t cmd;
	sts_t sts;

	mspc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	mspc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .command(command), .now_ms(now_ms),
		.capture_count(capture_count), .target_speed(target_speed), .cmd(cmd),
		.sts(sts), .duty(duty), .speed_rpm(speed_rpm), .edge_valid(edge_valid),
		.stall_active(stall_active)
	);
endmodule
`default_nettype wire

@@ rtl/mspc_checker.sv @@
// mspc_assert: port-level assertions, bound to the top level
// depends on motor_speed_pi_controller
`default_nettype none
module mspc_assert (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [11:0] duty,
	input wire logic        edge_valid,
	input wire logic        stall_active
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(duty)) else $error("out held");
	a_no_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("single item");
	a_stall_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stall_active |-> duty == 12'd0) else $error("stall duty");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({duty, edge_valid, stall_active})) else $error("unknown");
endmodule

bind motor_speed_pi_controller mspc_assert u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .duty(duty),
	.edge_valid(edge_valid), .stall_active(stall_active)
);
`default_nettype wire

@@ bench/mspc_checker.sv @@
// mspc_checker: watches the item and result channels of the speed controller,
// predicts each result from its own copy of the controller state and compares
// depends on mspc_pkg
`default_nettype none
module mspc_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [19:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic        command,
	input  wire logic [31:0] now_ms,
	input  wire logic [15:0] capture_count,
	input  wire logic [11:0] target_speed,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [11:0] duty,
	input  wire logic [12:0] speed_rpm,
	input  wire logic        edge_valid,
	input  wire logic        stall_active,
	output int               fail_count,
	output int               pending
);
	import mspc_pkg::*;

	typedef struct packed {
		logic [11:0] duty;
		logic [12:0] rpm;
		logic        ev;
		logic        stall;
	} ctl_result_t;

	ctl_result_t expected_q[$];

	logic [19:0] kp, ki, kd;
	logic [7:0]  ramp;
	logic [11:0] plim, kick;
	logic [15:0] tmo, stl;

	logic [15:0] prev_cap;
	logic        first_pend;
	logic [31:0] last_edge, last_valid;
	logic [16:0] hist [HIST_DEPTH];
	int          hwi, hfill;
	logic [16:0] filt;
	logic [15:0] setpt;
	longint      integ_acc, prev_err;
	logic        armed, recov;
	logic [31:0] stall_t0;
	logic [11:0] duty_r;

	task automatic clear_speed();
		for (int i = 0; i < HIST_DEPTH; i++) hist[i] = '0;
		hwi = 0;
		hfill = 0;
	endtask

	task automatic model_reset();
		kp = 20'd161409; ki = 20'd5160; kd = '0; ramp = 8'd15;
		plim = 12'd3360; kick = 12'd300; tmo = 16'd150; stl = 16'd2000;
		prev_cap = '0; first_pend = 1'b1; last_edge = '0; last_valid = '0;
		clear_speed();
		filt = '0; setpt = SETPOINT_RST; integ_acc = 0; prev_err = 0;
		armed = 1'b0; recov = 1'b0; stall_t0 = '0; duty_r = '0;
	endtask

	function automatic logic measure_edge(logic [31:0] t, logic [15:0] cap);
		longint iv;
		longint sum;
		logic [31:0] dt;
		dt = t - last_edge;
		if (dt > 32'd60) first_pend = 1'b1;
		last_edge = t;
		if (first_pend) begin
			prev_cap = cap;
			first_pend = 1'b0;
			return 1'b0;
		end
		iv = (cap > prev_cap) ? longint'(cap) - longint'(prev_cap)
			: (longint'(16'hFFFF) - longint'(prev_cap)) + longint'(cap) + 1;
		prev_cap = cap;
		if (iv > 1500 && iv < 60000) begin
			last_valid = t;
			hist[hwi] = 17'(120000000 / iv);
			hwi++;
			if (hfill < HIST_DEPTH) hfill++;
			if (hwi >= HIST_DEPTH) hwi = 0;
			sum = 0;
			for (int i = 0; i < hfill; i++) sum += longint'(hist[i]);
			filt = 17'(sum / hfill);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic control_tick(logic [31:0] t, logic [11:0] tgt_rpm);
		longint err, ig, imax, dv, sum, tgt, step;
		logic [31:0] dt;
		dt = t - last_valid;
		if (dt > {16'd0, tmo}) begin
			filt = '0;
			first_pend = 1'b1;
			clear_speed();
		end
		if (filt == 0 && setpt > 0) begin
			if (!armed) begin
				armed = 1'b1;
				stall_t0 = t;
			end
			dt = t - stall_t0;
			if (dt > {16'd0, stl}) recov = 1'b1;
		end else begin
			armed = 1'b0;
			recov = 1'b0;
		end
		if (recov) begin
			duty_r = '0;
			integ_acc = 0;
			dt = t - stall_t0;
			if (dt > 32'd3000) begin
				recov = 1'b0;
				stall_t0 = t;
			end
			return;
		end
		tgt = longint'(tgt_rpm) * 16;
		step = longint'(ramp) * 16;
		if (setpt < tgt) begin
			if (longint'(setpt) + step > tgt) setpt = 16'(tgt);
			else setpt = 16'(longint'(setpt) + step);
		end else if (setpt > tgt) begin
			setpt = (longint'(setpt) - tgt > step) ? 16'(longint'(setpt) - step) : 16'(tgt);
		end
		err = longint'(setpt) - longint'(filt);
		ig = integ_acc + err;
		if (ki >= 7) imax = (longint'(plim) << 20) / longint'(ki);
		else imax = longint'(plim) * 16;
		if (imax > 8388607) imax = 8388607;
		if (ig > imax) ig = imax;
		if (ig < -imax) ig = -imax;
		integ_acc = ig;
		dv = err - prev_err;
		sum = longint'(kp) * err + longint'(ki) * ig + longint'(kd) * dv;
		prev_err = err;
		if (sum > longint'(plim) * 1048576) duty_r = plim;
		else if (sum > 524288 && sum < longint'(kick) * 1048576) duty_r = kick;
		else if (sum <= 524288) duty_r = '0;
		else duty_r = 12'(sum >>> 20);
	endtask

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		ctl_result_t e, got;
		logic ev;
		if (!arst_n) begin
			model_reset();
			expected_q.delete();
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_PROP:  kp = cfg_data;
					REG_INTEG: ki = cfg_data;
					REG_DERIV: kd = cfg_data;
					REG_RAMP:  ramp = cfg_data[7:0];
					REG_PWM:   plim = cfg_data[11:0];
					REG_KICK:  kick = cfg_data[11:0];
					REG_TMO:   tmo = cfg_data[15:0];
					REG_STALL: stl = cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = '{duty, speed_rpm, edge_valid, stall_active};
				if (expected_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected result %h", got);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (e !== got) begin
						if (fail_count < 10)
							$display({"mismatch: exp duty %0d rpm %0d ev %0d st %0d,",
								" got duty %0d rpm %0d ev %0d st %0d"},
								e.duty, e.rpm, e.ev, e.stall,
								got.duty, got.rpm, got.ev, got.stall);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				ev = 1'b0;
				if (command) control_tick(now_ms, target_speed);
				else ev = measure_edge(now_ms, capture_count);
				expected_q.push_back('{duty_r, filt[16:4], ev, recov});
			end
		end
	end
endmodule
`default_nettype wire

@@ bench/tb.sv @@
// tb: stimulus and verdict for the motor speed pi controller
// depends on mspc_pkg, motor_speed_pi_controller, mspc_checker
`default_nettype none
module tb;
	import mspc_pkg::*;

	logic clk, arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [19:0] cfg_data;
	logic in_valid, in_stall, command;
	logic [31:0] now_ms;
	logic [15:0] capture_count;
	logic [11:0] target_speed;
	logic out_valid, out_stall;
	logic [11:0] duty;
	logic [12:0] speed_rpm;
	logic edge_valid, stall_active;
	int fail_count, pending;
	longint cycles;
	logic [31:0] clock_ms;
	logic [15:0] cap_now;
	logic [11:0] tgt_now;

	motor_speed_pi_controller DUT (.*);
	mspc_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 1500000) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// receiver stalls a random number of cycles before each transfer
	initial begin
		int w;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
			out_stall = (w != 0);
			if (w != 0) begin
				repeat (w) @(negedge clk);
				out_stall = 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [19:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic send(logic cmd, logic [31:0] t, logic [15:0] cap, logic [11:0] tgt,
			bit gaps);
		int w;
		@(negedge clk);
		w = (gaps && $urandom_range(0, 2) != 0) ? $urandom_range(0, 18) : 0;
		in_valid = 1'b0;
		repeat (w) @(negedge clk);
		in_valid = 1'b1;
		command = cmd;
		now_ms = t;
		capture_count = cap;
		target_speed = tgt;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic set_all(logic [19:0] p, logic [19:0] i, logic [19:0] d, logic [7:0] r,
			logic [11:0] pl, logic [11:0] k, logic [15:0] to, logic [15:0] st);
		write_reg(REG_PROP, p);
		write_reg(REG_INTEG, i);
		write_reg(REG_DERIV, d);
		write_reg(REG_RAMP, {12'd0, r});
		write_reg(REG_PWM, {8'd0, pl});
		write_reg(REG_KICK, {8'd0, k});
		write_reg(REG_TMO, {4'd0, to});
		write_reg(REG_STALL, {4'd0, st});
	endtask

	// a running motor: edges every few ms with intervals mostly in range, mixed with control ticks and time jumps
	task automatic run_phase(int n);
		int kind;
		for (int j = 0; j < n; j++) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				clock_ms += $urandom_range(0, 12);
				if ($urandom_range(0, 9) == 0) cap_now = 16'($urandom);
				else if ($urandom_range(0, 19) == 0) cap_now += 16'($urandom_range(0, 1600));
				else cap_now += 16'($urandom_range(1501, 59999));
				send(1'b0, clock_ms, cap_now, 12'($urandom), 1'b1);
			end else if (kind < 95) begin
				clock_ms += ($urandom_range(0, 15) == 0) ? $urandom_range(100, 4000)
					: $urandom_range(0, 10);
				if ($urandom_range(0, 9) == 0) tgt_now = 12'($urandom);
				send(1'b1, clock_ms, 16'($urandom), tgt_now, 1'b1);
			end else begin
				clock_ms = ($urandom_range(0, 1) != 0) ? $urandom : clock_ms + 70;
				send(1'($urandom_range(0, 1)), clock_ms, 16'($urandom), 12'($urandom), 1'b1);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; command = 1'b0; now_ms = '0; capture_count = '0;
		target_speed = '0;
		clock_ms = 32'd10; cap_now = 16'd0; tgt_now = 12'd800;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: edge gap, equal captures, window limits, wrap, timeout, stall, time wrap
		send(1'b0, 32'd10, 16'd100, 12'd0, 1'b0);
		send(1'b0, 32'd12, 16'd100, 12'd0, 1'b0);
		send(1'b0, 32'd14, 16'd1600, 12'd0, 1'b0);
		send(1'b0, 32'd16, 16'd3101, 12'd0, 1'b0);
		send(1'b0, 32'd18, 16'd63100, 12'd0, 1'b0);
		send(1'b0, 32'd20, 16'd2000, 12'd0, 1'b0);
		send(1'b0, 32'd22, 16'd4000, 12'd0, 1'b0);
		send(1'b1, 32'd23, 16'hFFFF, 12'd4095, 1'b0);
		send(1'b1, 32'd24, 16'd0, 12'd0, 1'b0);
		send(1'b0, 32'd200, 16'hFFFF, 12'hFFF, 1'b0);
		send(1'b1, 32'd400, 16'd0, 12'd1000, 1'b0);
		send(1'b1, 32'd2500, 16'd0, 12'd1000, 1'b0);
		send(1'b1, 32'd3000, 16'd0, 12'd1000, 1'b0);
		send(1'b1, 32'd5600, 16'd0, 12'd1000, 1'b0);
		send(1'b0, 32'hFFFF_FFF0, 16'd0, 12'd0, 1'b0);
		send(1'b0, 32'h0000_0005, 16'd5000, 12'd0, 1'b0);
		send(1'b1, 32'h0000_0006, 16'd0, 12'd0, 1'b0);
		clock_ms = 32'd10;
		drain();

		set_all(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 8'd255, 12'd4095, 12'd4095, 16'hFFFF, 16'hFFFF);
		run_phase(110);
		drain();
		set_all(20'd0, 20'd0, 20'd0, 8'd0, 12'd1, 12'd0, 16'd1, 16'd1);
		run_phase(90);
		drain();
		set_all(20'd70000, 20'd6, 20'd3000, 8'd40, 12'd2000, 12'd3000, 16'd40, 16'd300);
		run_phase(150);
		drain();
		set_all(20'd161409, 20'd5160, 20'd0, 8'd15, 12'd3360, 12'd300, 16'd150, 16'd2000);
		run_phase(150);
		drain();
		set_all(20'($urandom), 20'($urandom), 20'($urandom), 8'($urandom),
			12'($urandom_range(1, 4095)), 12'($urandom),
			16'($urandom_range(20, 400)), 16'($urandom_range(50, 3000)));
		run_phase(150);
		drain();

		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
`default_nettype wire
